// ----- rtl/sme_pkg.sv -----
// Shared types, constants and helpers for the stable matching enumerator.
// No dependencies; used by every module in rtl/ except sme_ram.
package sme_pkg;

  localparam int MAX_PAIRS   = 7;
  localparam int IDX_W       = 3;
  localparam int RANK_W      = 3;
  localparam int TABLE_DEPTH = MAX_PAIRS * MAX_PAIRS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 6;
  localparam int RESULT_CAP  = 42;
  localparam int MATCH_W     = IDX_W * MAX_PAIRS;
  localparam int MODE_W      = 2;
  localparam int PHASE_W     = 3;

  localparam logic [MODE_W-1:0] MODE_MAN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WOMAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  localparam logic [PHASE_W-1:0] READ_LAST = 3'd4;
  localparam logic [IDX_W-1:0]   SIZE_RST  = 3'd3;

  typedef struct packed {
    logic ld_man;
    logic ld_woman;
    logic init;
    logic found;
    logic pop;
    logic inc_cur;
    logic descend;
    logic clr_i;
    logic next_i;
    logic rd_en;
    logic [PHASE_W-1:0] phase;
    logic finish;
  } sme_cmd_t;

  typedef struct packed {
    logic at_full;
    logic cur_over;
    logic lvl_zero;
    logic i_last;
    logic fail;
    logic cap_hit;
  } sme_sts_t;

  // row * MAX_PAIRS + col
  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(row);
    return ADDR_W'(r * ADDR_W'(MAX_PAIRS)) + ADDR_W'(col);
  endfunction

endpackage

// ----- rtl/sme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sme_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 49
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/sme_ctrl.sv -----
// Search controller: accepts words, sequences the backtracking search.
// Depends on sme_pkg; drives sme_dp through sme_cmd_t, reads sme_sts_t.
module sme_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sme_pkg::MODE_W-1:0]       in_mode,
  input  sme_pkg::sme_sts_t                sts,
  output sme_pkg::sme_cmd_t                cmd,
  output logic                             busy
);
  import sme_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_READ   = 5'b00100,
    S_CMP    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.phase = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_mode == MODE_START) begin
            cmd.init  = 1'b1;
            state_nxt = S_EVAL;
          end else if (in_mode == MODE_MAN) begin
            cmd.ld_man = 1'b1;
          end else if (in_mode == MODE_WOMAN) begin
            cmd.ld_woman = 1'b1;
          end
        end
      end
      S_EVAL: begin
        if (sts.at_full) begin
          cmd.found = 1'b1;
          cmd.pop   = 1'b1;
          if (sts.cap_hit) begin
            state_nxt = S_FINISH;
          end
        end else if (sts.cur_over) begin
          if (sts.lvl_zero) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.pop = 1'b1;
          end
        end else if (sts.lvl_zero) begin
          cmd.descend = 1'b1;
        end else begin
          cmd.clr_i = 1'b1;
          phase_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (phase_r == READ_LAST) begin
          state_nxt = S_CMP;
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
      S_CMP: begin
        if (sts.fail) begin
          cmd.inc_cur = 1'b1;
          state_nxt   = S_EVAL;
        end else if (sts.i_last) begin
          cmd.descend = 1'b1;
          state_nxt   = S_EVAL;
        end else begin
          cmd.next_i = 1'b1;
          phase_nxt  = '0;
          state_nxt  = S_READ;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (phase_r <= READ_LAST))
    else $error("read phase out of range");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> !busy)
    else $error("search did not return to idle");

endmodule

// ----- rtl/sme_dp.sv -----
// Search datapath: preference tables, assignment stack, checks, result words.
// Depends on sme_pkg and sme_ram; commanded by sme_ctrl.
module sme_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sme_pkg::sme_cmd_t                   cmd,
  output sme_pkg::sme_sts_t                   sts,
  input  logic [sme_pkg::IDX_W-1:0]           in_person,
  input  logic [sme_pkg::IDX_W-1:0]           in_candidate,
  input  logic [sme_pkg::RANK_W-1:0]          in_rank_value,
  input  logic                                cfg_wr_en,
  input  logic [sme_pkg::IDX_W-1:0]           cfg_pair_count,
  output logic                                out_valid,
  output logic [sme_pkg::MATCH_W-1:0]         out_matching,
  output logic [sme_pkg::CNT_W-1:0]           out_ordinal,
  output logic                                out_last_flag
);
  import sme_pkg::*;

  logic [IDX_W-1:0]   pair_count_r;
  logic [IDX_W-1:0]   n_eff;
  logic [IDX_W-1:0]   partner_r [MAX_PAIRS];
  logic [IDX_W-1:0]   lvl_r, cur_r, i_r;
  logic [CNT_W-1:0]   count_r;
  logic               pend_v_r;
  logic [MATCH_W-1:0] pend_match_r;
  logic [CNT_W-1:0]   pend_ord_r;
  logic [RANK_W-1:0]  m_r [4];
  logic [RANK_W-1:0]  w_r [4];
  logic               out_valid_r, out_last_r;
  logic [MATCH_W-1:0] out_match_r;
  logic [CNT_W-1:0]   out_ord_r;

  logic [IDX_W-1:0]   rd_idx, wi, lvl_m1;
  logic [MATCH_W-1:0] packed_match;
  logic               in_range;
  logic [ADDR_W-1:0]  wr_addr, man_raddr, woman_raddr;
  logic [RANK_W-1:0]  man_rdata, woman_rdata;
  logic [1:0]         slot;

  assign n_eff  = (pair_count_r == '0) ? IDX_W'(1) : pair_count_r;
  assign lvl_m1 = lvl_r - 1'b1;
  assign rd_idx = cmd.pop ? lvl_m1 : i_r;
  assign wi     = partner_r[rd_idx];
  assign slot   = 2'(cmd.phase - 1'b1);

  always_comb begin
    for (int k = 0; k < MAX_PAIRS; k++) begin
      packed_match[k*IDX_W +: IDX_W] = partner_r[k];
    end
  end

  assign in_range = (in_person < IDX_W'(MAX_PAIRS)) && (in_candidate < IDX_W'(MAX_PAIRS));
  assign wr_addr  = tbl_addr(in_person, in_candidate);

  // m: man(lvl,wi) man(lvl,wn) man(i,wn) man(i,wi)
  // w: woman(wi,lvl) woman(wi,i) woman(wn,i) woman(wn,lvl)
  always_comb begin
    unique case (cmd.phase)
      3'd0: begin
        man_raddr   = tbl_addr(lvl_r, wi);
        woman_raddr = tbl_addr(wi, lvl_r);
      end
      3'd1: begin
        man_raddr   = tbl_addr(lvl_r, cur_r);
        woman_raddr = tbl_addr(wi, i_r);
      end
      3'd2: begin
        man_raddr   = tbl_addr(i_r, cur_r);
        woman_raddr = tbl_addr(cur_r, i_r);
      end
      3'd3: begin
        man_raddr   = tbl_addr(i_r, wi);
        woman_raddr = tbl_addr(cur_r, lvl_r);
      end
      default: begin
        man_raddr   = '0;
        woman_raddr = '0;
      end
    endcase
  end

  sme_ram #(.WIDTH(RANK_W), .DEPTH(TABLE_DEPTH)) u_man_tbl (
    .clk     (clk),
    .wr_en   (cmd.ld_man && in_range),
    .wr_addr (wr_addr),
    .wr_data (in_rank_value),
    .rd_addr (man_raddr),
    .rd_data (man_rdata)
  );

  sme_ram #(.WIDTH(RANK_W), .DEPTH(TABLE_DEPTH)) u_woman_tbl (
    .clk     (clk),
    .wr_en   (cmd.ld_woman && in_range),
    .wr_addr (wr_addr),
    .wr_data (in_rank_value),
    .rd_addr (woman_raddr),
    .rd_data (woman_rdata)
  );

  assign sts.at_full  = (lvl_r == n_eff);
  assign sts.cur_over = (cur_r >= n_eff);
  assign sts.lvl_zero = (lvl_r == '0);
  assign sts.i_last   = (i_r == lvl_m1);
  assign sts.cap_hit  = (count_r == CNT_W'(RESULT_CAP - 1));
  assign sts.fail     = (wi == cur_r) ||
                        ((m_r[0] < m_r[1]) && (w_r[0] < w_r[1])) ||
                        ((w_r[2] < w_r[3]) && (m_r[2] < m_r[3]));

  always_ff @(posedge clk) begin
    if (cmd.rd_en && (cmd.phase != '0)) begin
      m_r[slot] <= man_rdata;
      w_r[slot] <= woman_rdata;
    end
    if (cmd.found) begin
      pend_match_r <= packed_match;
      pend_ord_r   <= count_r + 1'b1;
    end
    if ((cmd.found || cmd.finish) && pend_v_r) begin
      out_match_r <= pend_match_r;
      out_ord_r   <= pend_ord_r;
      out_last_r  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r <= SIZE_RST;
      lvl_r        <= '0;
      cur_r        <= '0;
      i_r          <= '0;
      count_r      <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < MAX_PAIRS; k++) begin
        partner_r[k] <= '0;
      end
    end else begin
      out_valid_r <= (cmd.found || cmd.finish) && pend_v_r;
      if (cfg_wr_en) begin
        pair_count_r <= cfg_pair_count;
      end
      if (cmd.init) begin
        lvl_r    <= '0;
        cur_r    <= '0;
        i_r      <= '0;
        count_r  <= '0;
        pend_v_r <= 1'b0;
        for (int k = 0; k < MAX_PAIRS; k++) begin
          partner_r[k] <= '0;
        end
      end
      if (cmd.found) begin
        count_r  <= count_r + 1'b1;
        pend_v_r <= 1'b1;
      end
      if (cmd.finish) begin
        pend_v_r <= 1'b0;
        lvl_r    <= '0;
        cur_r    <= '0;
        for (int k = 0; k < MAX_PAIRS; k++) begin
          partner_r[k] <= '0;
        end
      end
      if (cmd.pop) begin
        lvl_r             <= lvl_m1;
        cur_r             <= wi + 1'b1;
        partner_r[lvl_m1] <= '0;
      end
      if (cmd.inc_cur) begin
        cur_r <= cur_r + 1'b1;
      end
      if (cmd.descend) begin
        partner_r[lvl_r] <= cur_r;
        lvl_r            <= lvl_r + 1'b1;
        cur_r            <= '0;
      end
      if (cmd.clr_i) begin
        i_r <= '0;
      end
      if (cmd.next_i) begin
        i_r <= i_r + 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_matching  = out_match_r;
  assign out_ordinal   = out_ord_r;
  assign out_last_flag = out_last_r;

  a_ord_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ord_r != '0))
    else $error("result word with zero ordinal");

  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= n_eff)
    else $error("search level beyond size");

  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= n_eff)
    else $error("candidate beyond size");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result word after last");

endmodule

// ----- rtl/stable_matching_enumerator.sv -----
// Stable matching enumerator: a load word with both indices below 7 writes one
// preference rank, a start word enumerates all stable matchings by backtracking
// search. A load word leaves busy low. A start word holds busy high for the whole
// search: each candidate woman tried for man L is checked against each earlier man,
// each pop or find is a single step, and the search closes with a finish step,
// also when it stops at the result cap.
// The check of one pair against an earlier pair needs 8 rank reads, and each rank
// table has one read port, so it takes 4 reads, a last capture and a compare.
// Results appear one at a time on out_valid for a single cycle and cannot be stalled;
// each is delivered when the next one is found or when the search ends, and the
// final one carries out_last_flag and is on the outputs in the first cycle with busy
// low. At most 42 results are given per search.
// The user must write cfg_pair_count only while busy is low; the block does not enforce it.
module stable_matching_enumerator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sme_pkg::MODE_W-1:0]  in_mode,
  input  logic [sme_pkg::IDX_W-1:0]   in_person,
  input  logic [sme_pkg::IDX_W-1:0]   in_candidate,
  input  logic [sme_pkg::RANK_W-1:0]  in_rank_value,
  input  logic                        cfg_wr_en,
  input  logic [sme_pkg::IDX_W-1:0]   cfg_pair_count,
  output logic                        out_valid,
  output logic [sme_pkg::MATCH_W-1:0] out_matching,
  output logic [sme_pkg::CNT_W-1:0]   out_ordinal,
  output logic                        out_last_flag
);
  import sme_pkg::*;

  sme_cmd_t cmd;
  sme_sts_t sts;

  sme_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  sme_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_person      (in_person),
    .in_candidate   (in_candidate),
    .in_rank_value  (in_rank_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_pair_count (cfg_pair_count),
    .out_valid      (out_valid),
    .out_matching   (out_matching),
    .out_ordinal    (out_ordinal),
    .out_last_flag  (out_last_flag)
  );

endmodule
